// File: src/wav_pcm_to_float_converter_core_macros.svh
// Assertion helpers used by the converter core source.
`ifndef WAV_PCM_TO_FLOAT_CONVERTER_CORE_MACROS_SVH
`define WAV_PCM_TO_FLOAT_CONVERTER_CORE_MACROS_SVH
// Implication checked on every clock, off while in reset.
`define WPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked on the next clock.
`define WPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/wpf_pkg.sv
package wpf_pkg;

  localparam int MaxChannelsDef = 16;

  localparam logic [1:0] ENC_PCM   = 2'd0;
  localparam logic [1:0] ENC_FLOAT = 2'd1;

  localparam logic [1:0] REG_SIZE = 2'd0;
  localparam logic [1:0] REG_ENC  = 2'd1;
  localparam logic [1:0] REG_CHAN = 2'd2;

  // Sample format decoded from the registers.
  localparam logic [2:0] FMT_BAD  = 3'd0;
  localparam logic [2:0] FMT_U8   = 3'd1;
  localparam logic [2:0] FMT_S16  = 3'd2;
  localparam logic [2:0] FMT_S24  = 3'd3;
  localparam logic [2:0] FMT_S32  = 3'd4;
  localparam logic [2:0] FMT_F32  = 3'd5;

  // Assembled sample handed from the byte collector to the converter.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  fmt;
    logic        bad;
  } smp_t;

  // Signed integer (up to 32 bits, value = v * 2^-scale) to float bits, RNE.
  function automatic logic [31:0] int_to_float(input logic [31:0] v, input logic [7:0] scale);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [5:0]  lz;
    logic [23:0] man;
    logic        g, st;
    logic [24:0] rnd;
    logic [7:0]  ex;
    sgn = v[31];
    mag = sgn ? (~v + 32'd1) : v;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 6'(31 - i);
    end
    norm = mag << lz[4:0];
    man  = norm[31:8];
    g    = norm[7];
    st   = |norm[6:0];
    rnd  = {1'b0, man} + 25'(g & (st | man[0]));
    ex   = 8'(8'd158 - {2'b0, lz} - scale);
    if (rnd[24]) begin
      ex  = ex + 8'd1;
      rnd = rnd >> 1;
    end
    if (mag == 32'd0) int_to_float = 32'd0;
    else int_to_float = {sgn, ex, rnd[22:0]};
  endfunction

endpackage

// File: src/wpf_collect.sv
// Byte gathering and channel tracking; the output sample is combinational from held and current bytes.
module wpf_collect #(
  parameter int MAX_CHANNELS = wpf_pkg::MaxChannelsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic [6:0]            size_bits,
  input  logic [1:0]            enc,
  input  logic [4:0]            chan_cnt,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  output logic                  emit,
  output wpf_pkg::smp_t         smp,
  output logic [3:0]            chan_idx,
  output logic                  last
);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] part_r, part_nxt;
  logic [CW-1:0] chan_r, chan_nxt;
  logic [2:0]  fmt;
  logic [1:0]  nlast;
  logic [8:0]  chans;
  logic [CW-1:0] cur;
  logic [31:0] word;

  always_comb begin
    case (size_bits)
      7'd8:  fmt = wpf_pkg::FMT_U8;
      7'd16: fmt = wpf_pkg::FMT_S16;
      7'd24: fmt = (enc == wpf_pkg::ENC_PCM) ? wpf_pkg::FMT_S24 : wpf_pkg::FMT_BAD;
      7'd32: fmt = (enc == wpf_pkg::ENC_PCM) ? wpf_pkg::FMT_S32 :
                   (enc == wpf_pkg::ENC_FLOAT) ? wpf_pkg::FMT_F32 : wpf_pkg::FMT_BAD;
      default: fmt = wpf_pkg::FMT_BAD;
    endcase
    case (fmt)
      wpf_pkg::FMT_U8:  nlast = 2'd0;
      wpf_pkg::FMT_S16: nlast = 2'd1;
      wpf_pkg::FMT_S24: nlast = 2'd2;
      default:          nlast = 2'd3;
    endcase
    chans = (chan_cnt == 5'd0) ? 9'd1 : {4'b0, chan_cnt};
    if (chans > 9'(MAX_CHANNELS)) chans = 9'(MAX_CHANNELS);
    cur = (32'(chan_r) >= 32'(chans)) ? '0 : chan_r;
    // each byte lands at its own position; the final one at the top slot
    word = {8'b0, part_r} | ({24'b0, data_byte} << {pos_r, 3'b000});
    last = (32'(cur) + 32'd1 >= 32'(chans));
    chan_idx = 4'(cur);
    smp.word = word;
    smp.fmt  = fmt;
    smp.bad  = (fmt == wpf_pkg::FMT_BAD);
    emit = take && (smp.bad || pos_r == nlast);
    pos_nxt = pos_r;
    part_nxt = part_r;
    chan_nxt = chan_r;
    if (clear) begin
      pos_nxt = '0;
      part_nxt = '0;
      chan_nxt = '0;
    end else if (take && !smp.bad) begin
      if (pos_r == nlast) begin
        pos_nxt = '0;
        part_nxt = '0;
        chan_nxt = last ? '0 : CW'(32'(cur) + 32'd1);
      end else begin
        pos_nxt = pos_r + 2'd1;
        part_nxt = word[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      part_r <= '0;
      chan_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      part_r <= part_nxt;
      chan_r <= chan_nxt;
    end
  end
endmodule

// File: src/wpf_convert.sv
// Sample word to IEEE single bits.
module wpf_convert (
  input  wpf_pkg::smp_t smp,
  output logic [31:0]   fbits
);
  always_comb begin
    case (smp.fmt)
      wpf_pkg::FMT_U8:
        fbits = wpf_pkg::int_to_float(32'({24'b0, smp.word[7:0]} - 32'h80), 8'd7);
      wpf_pkg::FMT_S16:
        fbits = wpf_pkg::int_to_float({{16{smp.word[15]}}, smp.word[15:0]}, 8'd15);
      wpf_pkg::FMT_S24:
        fbits = wpf_pkg::int_to_float({smp.word[23:0], 8'b0}, 8'd31);
      wpf_pkg::FMT_S32:
        fbits = wpf_pkg::int_to_float(smp.word, 8'd31);
      wpf_pkg::FMT_F32:
        fbits = smp.word;
      default:
        fbits = 32'd0;
    endcase
  end
endmodule

// File: src/wav_pcm_to_float_converter_core.sv
// WAV PCM to float converter.
// in_*: one data byte per transfer (in_tdata), little-endian WAV sample data.
// out_*: one converted sample per transfer. tdata = float bits,
//   tuser from bit 0 up:
//   [3:0] channel_index, [4] frame_last, [5] status.
// cfg_*: index 0 sample size bits, 1 encoding, 2 channel count; any
//   listed write restarts byte and channel counting. Write only when idle.
// Throughput: one byte per cycle while in_tready is high. The byte that completes
//   a sample gives its result from the output register in the next cycle. Unsupported formats
//   answer every byte with status set and zero float bits.
// Conversion is one combinational pass (assembly, leading-zero count,
//   normalize and round) from the byte input into the output register.
// Stall: in_tready follows out_tready when a result is held; a held result
//   stays stable until taken, new bytes still enter when the register
//   frees in the same cycle.
// Reset (synchronous, rst_n low): 16-bit PCM, two channels, counters clear,
//   output register empty.
`include "wav_pcm_to_float_converter_core_macros.svh"
module wav_pcm_to_float_converter_core #(
  parameter int MAX_CHANNELS = wpf_pkg::MaxChannelsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] float_bits
  output logic [7:0]  out_tuser,  // [3:0] channel_index, [4] frame_last, [5] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  logic [6:0] size_r;
  logic [1:0] enc_r;
  logic [4:0] chan_r;
  logic       cfg_hit;
  logic       take, emit, last;
  logic [3:0] cidx;
  logic [31:0] fbits;
  wpf_pkg::smp_t smp;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r;
  logic [7:0]  ou_r;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && (cfg_index == wpf_pkg::REG_SIZE ||
                   cfg_index == wpf_pkg::REG_ENC || cfg_index == wpf_pkg::REG_CHAN);
  assign in_tready = !ov_r || out_tready;
  assign take = in_tvalid && in_tready;

  wpf_collect #(.MAX_CHANNELS(MAX_CHANNELS)) u_collect (
    .clk(clk), .rst_n(rst_n), .clear(cfg_hit), .size_bits(size_r), .enc(enc_r),
    .chan_cnt(chan_r), .take(take), .data_byte(in_tdata), .emit(emit), .smp(smp),
    .chan_idx(cidx), .last(last)
  );

  wpf_convert u_convert (.smp(smp), .fbits(fbits));

  assign ov_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 7'd16;
      enc_r <= wpf_pkg::ENC_PCM;
      chan_r <= 5'd2;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          wpf_pkg::REG_SIZE: size_r <= cfg_data;
          wpf_pkg::REG_ENC:  enc_r <= cfg_data[1:0];
          wpf_pkg::REG_CHAN: chan_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      od_r <= smp.bad ? 32'd0 : fbits;
      ou_r <= smp.bad ? 8'h20 : {2'b00, 1'b0, last, cidx};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  `WPF_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "held result changed")
  `WPF_ASSERT_IMPL(a_bad_zero, out_tvalid && out_tuser[5], out_tdata == 32'd0 &&
    out_tuser[4:0] == 5'd0, "bad status with payload")
  `WPF_ASSERT_NEXT(a_emit, emit, out_tvalid, "result lost")
endmodule

// File: verif/tb_wav_pcm_to_float_converter_core.sv
`timescale 1ns / 1ps
module tb_wav_pcm_to_float_converter_core;

  // encodings beyond the package's two
  localparam logic [1:0] ENC_OTHER  = 2'd2;
  localparam logic [1:0] ENC_OTHER3 = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;  // index past the register list
  localparam int         CHAN_CAP   = wpf_pkg::MaxChannelsDef;

  typedef struct packed {
    logic [31:0] bits;
    logic [3:0]  chan;
    logic        last;
    logic        status;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] float_bits
  logic [7:0]  out_tuser;   // [3:0] channel_index, [4] frame_last, [5] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  wav_pcm_to_float_converter_core u_dut (.*);

  // shadow registers and progress counters of the converter
  logic [6:0]  size_bits;
  logic [1:0]  enc_kind;
  logic [4:0]  chan_cnt;
  logic [1:0]  byte_pos;
  logic [23:0] partial;
  logic [3:0]  chan_pos;

  sample_t     pending_samples[$];
  int          mismatches;
  int          bytes_sent;
  int          samples_seen;
  int          bad_seen;
  bit          no_gap;       // suppresses idle cycles on both sides
  bit          hold_req;     // asks the receiver for a long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed value times 2^-scale to single precision, round to nearest even.
  function automatic logic [31:0] fixed_to_single(input longint v, input int scale);
    longint mag, keep, rem, half;
    int     msb, sh, ex;
    logic   sgn;
    sgn = (v < 0);
    mag = sgn ? -v : v;
    if (mag == 0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 40; i++) if (mag[i]) msb = i;
    ex = msb - scale + 127;
    if (msb <= 23) begin
      keep = mag << (23 - msb);
    end else begin
      sh   = msb - 23;
      keep = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        ex++;
      end
    end
    return {sgn, 8'(ex), keep[22:0]};
  endfunction

  function automatic int sample_bytes();
    case (size_bits)
      7'd8:    return 1;
      7'd16:   return 2;
      7'd24:   return (enc_kind == wpf_pkg::ENC_PCM) ? 3 : 0;
      7'd32:   return (enc_kind == wpf_pkg::ENC_PCM ||
                       enc_kind == wpf_pkg::ENC_FLOAT) ? 4 : 0;
      default: return 0;
    endcase
  endfunction

  // Advance the shadow state by one byte; queue a sample when one is due.
  task automatic convert_byte(input logic [7:0] b);
    int          n, chans;
    logic [31:0] word;
    sample_t     s;
    n = sample_bytes();
    if (n == 0) begin
      s = '{bits: 32'd0, chan: 4'd0, last: 1'b0, status: 1'b1};
      pending_samples.push_back(s);
      return;
    end
    if (byte_pos + 1 < n) begin
      partial  = partial | (24'(b) << (8 * byte_pos));
      byte_pos = byte_pos + 2'd1;
      return;
    end
    word = {8'd0, partial} | (32'(b) << (8 * (n - 1)));
    case (n)
      1: s.bits = fixed_to_single(longint'(word[7:0]) - 128, 7);
      2: s.bits = fixed_to_single(longint'($signed(word[15:0])), 15);
      3: s.bits = fixed_to_single(longint'($signed({word[23:0], 8'd0})), 31);
      default: begin
        if (enc_kind == wpf_pkg::ENC_PCM)
          s.bits = fixed_to_single(longint'($signed(word)), 31);
        else s.bits = word;
      end
    endcase
    chans = (chan_cnt == 0) ? 1 : (chan_cnt > CHAN_CAP) ? CHAN_CAP : chan_cnt;
    if (chan_pos >= chans) chan_pos = 4'd0;
    s.chan   = chan_pos;
    s.last   = (chan_pos + 1 >= chans);
    s.status = 1'b0;
    chan_pos = s.last ? 4'd0 : chan_pos + 4'd1;
    byte_pos = 2'd0;
    partial  = 24'd0;
    pending_samples.push_back(s);
  endtask

  // One byte transfer; in_tvalid stays high afterwards so back-to-back
  // bytes never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (!no_gap && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    convert_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and wait until every queued sample is out, plus a few cycles.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      wpf_pkg::REG_SIZE: size_bits = val;
      wpf_pkg::REG_ENC:  enc_kind  = val[1:0];
      wpf_pkg::REG_CHAN: chan_cnt  = val[4:0];
      default:  return;   // unlisted index: no effect, progress kept
    endcase
    byte_pos = 2'd0;
    partial  = 24'd0;
    chan_pos = 4'd0;
  endtask

  task automatic set_format(input logic [6:0] sz, input logic [1:0] enc, input logic [6:0] ch);
    write_reg(wpf_pkg::REG_SIZE, sz);
    write_reg(wpf_pkg::REG_ENC, {5'd0, enc});
    write_reg(wpf_pkg::REG_CHAN, ch);
  endtask

  task automatic send_word(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) send_byte(w[8*i +: 8]);
  endtask

  // Reset defaults: 16-bit PCM stereo, full-scale and zero samples.
  task automatic test_reset_format();
    send_word(32'h8000, 2);
    send_word(32'h7fff, 2);
    send_word(32'h0000, 2);
    send_word(32'hffff, 2);
    send_word(32'h0001, 2);
  endtask

  // 8-bit unsigned ignores the encoding; channel count zero acts as mono.
  task automatic test_unsigned8();
    set_format(7'd8, ENC_OTHER3, 7'd0);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(8'h7f);
  endtask

  task automatic test_signed24();
    set_format(7'd24, wpf_pkg::ENC_PCM, 7'd3);
    send_word(32'h800000, 3);
    send_word(32'h7fffff, 3);
    send_word(32'hffffff, 3);
    send_word(32'h000000, 3);
  endtask

  // 32-bit PCM needs rounding; channel count above the cap saturates.
  task automatic test_signed32();
    set_format(7'd32, wpf_pkg::ENC_PCM, 7'd31);
    send_word(32'h7fffffff, 4);
    send_word(32'h80000000, 4);
    send_word(32'h01000001, 4);
    send_word(32'h01000003, 4);
  endtask

  task automatic test_float32();
    set_format(7'd32, wpf_pkg::ENC_FLOAT, 7'd16);
    send_word(32'h3f800000, 4);
    send_word(32'hffffffff, 4);
  endtask

  // Unsupported formats answer every byte with status set.
  task automatic test_bad_formats();
    set_format(7'd0, wpf_pkg::ENC_PCM, 7'd2);
    send_byte(8'h5a);
    write_reg(wpf_pkg::REG_SIZE, 7'd127);
    send_byte(8'ha5);
    write_reg(wpf_pkg::REG_SIZE, 7'd64);
    send_byte(8'h33);
    set_format(7'd24, wpf_pkg::ENC_FLOAT, 7'd1);
    send_byte(8'h11);
    set_format(7'd32, ENC_OTHER, 7'd1);
    send_byte(8'h22);
  endtask

  // An unlisted register index leaves a half-built sample alone.
  task automatic test_unlisted_index();
    set_format(7'd16, wpf_pkg::ENC_PCM, 7'd2);
    send_byte(8'h34);
    write_reg(REG_NONE, 7'h7f);
    send_byte(8'h12);
  endtask

  // Output held off long enough that the input must stall.
  task automatic test_backpressure();
    set_format(7'd8, wpf_pkg::ENC_PCM, 7'd4);
    no_gap   = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_byte(8'($urandom));
    no_gap = 1'b0;
  endtask

  task automatic test_random_streams();
    int n, len;
    logic [6:0] sz;
    logic [1:0] enc;
    while (bytes_sent < 1100) begin
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(4))
          0: begin sz = 7'd8;  enc = 2'($urandom); end
          1: begin sz = 7'd16; enc = 2'($urandom); end
          2: begin sz = 7'd24; enc = wpf_pkg::ENC_PCM; end
          3: begin sz = 7'd32; enc = wpf_pkg::ENC_PCM; end
          default: begin sz = 7'd32; enc = wpf_pkg::ENC_FLOAT; end
        endcase
      end else begin
        sz  = 7'($urandom);
        enc = 2'($urandom);
      end
      set_format(sz, enc, 7'($urandom_range(0, 31)));
      n   = sample_bytes();
      len = (n == 0) ? $urandom_range(2, 8) : n * $urandom_range(4, 24);
      if ($urandom_range(7) == 0) len += 1;   // leave a sample unfinished
      no_gap = ($urandom_range(5) == 0);
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
      no_gap = 1'b0;
    end
  endtask

  // Receiver: random ready, one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= no_gap || ($urandom_range(99) >= 9);
      end
    end
  end

  // Result checker: compare each transfer with the oldest expected sample.
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata=%h tuser=%h", out_tdata, out_tuser);
      end else begin
        want = pending_samples.pop_front();
        if (out_tdata != want.bits || out_tuser[3:0] != want.chan ||
            out_tuser[4] != want.last || out_tuser[5] != want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: want bits=%h ch=%0d last=%b st=%b, ",
                      "got bits=%h ch=%0d last=%b st=%b"},
                     want.bits, want.chan, want.last, want.status,
                     out_tdata, out_tuser[3:0], out_tuser[4], out_tuser[5]);
        end
        if (want.status) bad_seen++;
        else samples_seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = 2'd0;
    cfg_data  = 7'd0;
    no_gap    = 1'b0;
    hold_req  = 1'b0;
    size_bits = 7'd16;
    enc_kind  = wpf_pkg::ENC_PCM;
    chan_cnt  = 5'd2;
    byte_pos  = 2'd0;
    partial   = 24'd0;
    chan_pos  = 4'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_format();
    test_unsigned8();
    test_signed24();
    test_signed32();
    test_float32();
    test_bad_formats();
    test_unlisted_index();
    test_backpressure();
    test_random_streams();
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes: %0d converted samples, %0d bad-format replies",
             bytes_sent, samples_seen, bad_seen);
    $display("formats u8/s16/s24/s32/f32 and unsupported, channel counts 0..31, long output stall");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_samples.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
